[design/dmxtx_pkg.sv]
// Shared widths, codes, register defaults and types for the DMX512 frame transmitter.
package dmxtx_pkg;

  localparam int DMX_CHANNELS   = 512;

  localparam int KIND_W         = 2;
  localparam int CH_INDEX_W     = 9;
  localparam int BYTE_W         = 8;
  localparam int FRAME_LEN_W    = 10;
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int TIMER_W        = 16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_BIT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BREAK_TICKS   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAB_TICKS     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE         = 8'd3;

  // register reset values
  localparam logic [TIMER_W-1:0] RST_TICKS_PER_BIT = 16'd4;
  localparam logic [TIMER_W-1:0] RST_BREAK_TICKS   = 16'd120;
  localparam logic [TIMER_W-1:0] RST_MAB_TICKS     = 16'd12;
  localparam logic [BYTE_W-1:0]  RST_SCALE         = 8'd1;

  typedef struct packed {
    logic [TIMER_W-1:0] ticks_per_bit;
    logic [TIMER_W-1:0] break_ticks;
    logic [TIMER_W-1:0] mab_ticks;
    logic [BYTE_W-1:0]  scale;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [CH_INDEX_W-1:0]  channel_index;
    logic [BYTE_W-1:0]      channel_value;
    logic [BYTE_W-1:0]      start_code;
    logic                   raw_frame;
    logic [FRAME_LEN_W-1:0] frame_length;
  } item_t;

  typedef struct packed {
    logic tx_level;
    logic busy_res;
    logic frame_done;
  } res_t;

endpackage

[design/dmxtx_in_if.sv]
// Input request channel: valid/ready plus one input item.
interface dmxtx_in_if;
  import dmxtx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [CH_INDEX_W-1:0]  channel_index;
  logic [BYTE_W-1:0]      channel_value;
  logic [BYTE_W-1:0]      start_code;
  logic                   raw_frame;
  logic [FRAME_LEN_W-1:0] frame_length;

  modport source (output valid, kind, channel_index, channel_value, start_code,
                  raw_frame, frame_length, input ready);
  modport sink   (input valid, kind, channel_index, channel_value, start_code,
                  raw_frame, frame_length, output ready);
endinterface

[design/dmxtx_out_if.sv]
// Result channel: valid/ready plus line level, busy and frame-done.
interface dmxtx_out_if;
  logic valid;
  logic ready;
  logic tx_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, tx_level, busy_res, frame_done, input ready);
  modport sink   (input valid, tx_level, busy_res, frame_done, output ready);
endinterface

[design/dmxtx_cfg_if.sv]
// Register write channel: valid/ready plus register index and write data.
interface dmxtx_cfg_if;
  import dmxtx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/dmxtx_cfg_regs.sv]
// Configuration registers: timing periods and channel scale.
module dmxtx_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [dmxtx_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [dmxtx_pkg::CFG_DATA_W-1:0]  wr_data,
  output dmxtx_pkg::cfg_t                  cfg
);
  import dmxtx_pkg::*;

  cfg_t               cfg_r;
  cfg_t               cfg_nxt;
  logic [TIMER_W-1:0] period;

  // a zero period behaves as one
  assign period = (wr_data == '0) ? TIMER_W'(1) : wr_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_TICKS_PER_BIT: cfg_nxt.ticks_per_bit = period;
        REG_BREAK_TICKS:   cfg_nxt.break_ticks   = period;
        REG_MAB_TICKS:     cfg_nxt.mab_ticks     = period;
        REG_SCALE:         cfg_nxt.scale         = wr_data[BYTE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_bit <= RST_TICKS_PER_BIT;
      cfg_r.break_ticks   <= RST_BREAK_TICKS;
      cfg_r.mab_ticks     <= RST_MAB_TICKS;
      cfg_r.scale         <= RST_SCALE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/dmxtx_store.sv]
// Channel byte store: one write port, one registered read port with write bypass.
module dmxtx_store #(
  parameter int CHANNEL_COUNT = dmxtx_pkg::DMX_CHANNELS,
  parameter int AW            = 9
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [dmxtx_pkg::BYTE_W-1:0]  wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [dmxtx_pkg::BYTE_W-1:0]  rd_data
);
  import dmxtx_pkg::*;

  logic [BYTE_W-1:0] mem [0:CHANNEL_COUNT-1];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-cycle write to the address being fetched is forwarded
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/dmxtx_seq.sv]
// Frame sequencer: break, mark-after-break and UART character timing.
module dmxtx_seq #(
  parameter int CHANNEL_COUNT = dmxtx_pkg::DMX_CHANNELS,
  parameter int AW            = 9,
  parameter int PW            = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_fire,
  input  dmxtx_pkg::item_t             item,
  input  dmxtx_pkg::cfg_t              cfg,
  input  logic [dmxtx_pkg::BYTE_W-1:0] rd_data,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [dmxtx_pkg::BYTE_W-1:0] wr_data,
  output logic [AW-1:0]                rd_addr,
  output dmxtx_pkg::res_t              res
);
  import dmxtx_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BREAK = 2'd1;
  localparam logic [1:0] PH_MAB   = 2'd2;
  localparam logic [1:0] PH_SEND  = 2'd3;
  localparam logic [3:0] LAST_BIT = 4'd10;
  localparam logic [3:0] LAST_DATA_BIT = 4'd8;
  localparam logic [FRAME_LEN_W-1:0] COUNT_LEN = FRAME_LEN_W'(CHANNEL_COUNT);
  localparam logic [PW-1:0]          COUNT_PTR = PW'(CHANNEL_COUNT);

  logic [1:0]          phase_r,      phase_nxt;
  logic [TIMER_W-1:0]  tick_count_r, tick_count_nxt;
  logic [3:0]          bit_index_r,  bit_index_nxt;
  logic [BYTE_W-1:0]   shift_byte_r, shift_byte_nxt;
  logic [PW-1:0]       byte_ptr_r,   byte_ptr_nxt;
  logic [PW-1:0]       frame_bytes_r, frame_bytes_nxt;
  logic                raw_mode_r,   raw_mode_nxt;
  logic                done_r,       done_nxt;

  logic [TIMER_W-1:0]     limit;
  logic [TIMER_W:0]       tick_inc;
  logic                   period_over;
  logic [FRAME_LEN_W-1:0] len_sat;
  logic [2*BYTE_W-1:0]    scaled;
  logic                   level_cur;
  logic                   level_nxt;

  function automatic logic line_level(input logic [1:0] ph, input logic [3:0] bi,
                                      input logic [BYTE_W-1:0] sb);
    logic [3:0] pos;
    pos = bi - 4'd1;
    if (ph == PH_BREAK)           return 1'b0;
    else if (ph != PH_SEND)       return 1'b1;
    else if (bi == 4'd0)          return 1'b0;
    else if (bi <= LAST_DATA_BIT) return sb[pos[2:0]];
    else                          return 1'b1;
  endfunction

  always_comb begin
    case (phase_r)
      PH_BREAK: limit = cfg.break_ticks;
      PH_MAB:   limit = cfg.mab_ticks;
      default:  limit = cfg.ticks_per_bit;
    endcase
  end

  assign tick_inc    = {1'b0, tick_count_r} + (TIMER_W+1)'(1);
  assign period_over = (tick_inc >= {1'b0, limit});
  assign len_sat     = (item.frame_length > COUNT_LEN) ? COUNT_LEN : item.frame_length;
  assign scaled      = rd_data * cfg.scale;

  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    bit_index_nxt   = bit_index_r;
    shift_byte_nxt  = shift_byte_r;
    byte_ptr_nxt    = byte_ptr_r;
    frame_bytes_nxt = frame_bytes_r;
    raw_mode_nxt    = raw_mode_r;
    done_nxt        = done_r;
    if (item_fire) begin
      case (item.kind)
        KIND_START: begin
          raw_mode_nxt    = item.raw_frame;
          frame_bytes_nxt = item.raw_frame ? PW'(len_sat) : COUNT_PTR;
          shift_byte_nxt  = item.start_code;
          byte_ptr_nxt    = '0;
          bit_index_nxt   = '0;
          tick_count_nxt  = '0;
          done_nxt        = 1'b0;
          phase_nxt       = PH_BREAK;
        end
        KIND_TICK: begin
          if (phase_r != PH_IDLE) begin
            tick_count_nxt = period_over ? '0 : tick_inc[TIMER_W-1:0];
            if (period_over) begin
              case (phase_r)
                PH_BREAK: phase_nxt = PH_MAB;
                PH_MAB: begin
                  phase_nxt     = PH_SEND;
                  bit_index_nxt = '0;
                end
                default: begin
                  if (bit_index_r < LAST_BIT) begin
                    bit_index_nxt = bit_index_r + 4'd1;
                  end else if (byte_ptr_r < frame_bytes_r) begin
                    // rd_data holds the current store entry at byte_ptr_r
                    shift_byte_nxt = raw_mode_r ? rd_data : scaled[BYTE_W-1:0];
                    byte_ptr_nxt   = byte_ptr_r + PW'(1);
                    bit_index_nxt  = '0;
                  end else begin
                    phase_nxt     = PH_IDLE;
                    bit_index_nxt = '0;
                    done_nxt      = 1'b1;
                  end
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      bit_index_r   <= '0;
      shift_byte_r  <= '0;
      byte_ptr_r    <= '0;
      frame_bytes_r <= '0;
      raw_mode_r    <= 1'b0;
      done_r        <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      bit_index_r   <= bit_index_nxt;
      shift_byte_r  <= shift_byte_nxt;
      byte_ptr_r    <= byte_ptr_nxt;
      frame_bytes_r <= frame_bytes_nxt;
      raw_mode_r    <= raw_mode_nxt;
      done_r        <= done_nxt;
    end
  end

  // store access: fetch the entry the pointer will name next cycle
  assign wr_en   = item_fire && (item.kind == KIND_WRITE) &&
                   ({1'b0, item.channel_index} < COUNT_LEN);
  assign wr_addr = AW'(item.channel_index);
  assign wr_data = item.channel_value;
  assign rd_addr = byte_ptr_nxt[AW-1:0];

  assign level_cur = line_level(phase_r, bit_index_r, shift_byte_r);
  assign level_nxt = line_level(phase_nxt, bit_index_nxt, shift_byte_nxt);

  // a tick reports the level driven during it; other requests report the new level
  assign res.tx_level   = (item.kind == KIND_TICK) ? level_cur : level_nxt;
  assign res.busy_res   = (phase_nxt != PH_IDLE);
  assign res.frame_done = done_nxt;

endmodule

[design/dmx512_frame_transmitter_top.sv]
// DMX512 frame transmitter top level: channels, registers, store and sequencer.
// A result is registered in the output register when its request is taken.
// Throughput: one request per cycle unless output stalls; the store has one write and
//   one read port; the next byte is prefetched every cycle, so ticks and writes stream.
// Reset (rst_n low, synchronous): sequencer idle, counters zero, registers at defaults,
//   output empty. The channel store is not cleared; its entries hold junk until written.
module dmx512_frame_transmitter_top #(
  parameter int CHANNEL_COUNT = dmxtx_pkg::DMX_CHANNELS
) (
  input logic         clk,
  input logic         rst_n,
  dmxtx_in_if.sink    in_ch,
  dmxtx_out_if.source out_ch,
  dmxtx_cfg_if.sink   cfg_ch
);
  import dmxtx_pkg::*;

  // store address width and a pointer width that can also hold the channel count
  localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int PW = $clog2(CHANNEL_COUNT + 1);

  cfg_t              cfg;
  item_t             item;
  res_t              res;
  logic              in_fire;
  logic              st_wr_en;
  logic [AW-1:0]     st_wr_addr;
  logic [BYTE_W-1:0] st_wr_data;
  logic [AW-1:0]     st_rd_addr;
  logic [BYTE_W-1:0] st_rd_data;

  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  // Register writes are always taken; the user only writes while idle.
  assign cfg_ch.ready = 1'b1;

  dmxtx_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // The output register decouples the two sides: a new request is taken whenever
  // the register is empty or its result is being taken in this same cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign item.kind          = in_ch.kind;
  assign item.channel_index = in_ch.channel_index;
  assign item.channel_value = in_ch.channel_value;
  assign item.start_code    = in_ch.start_code;
  assign item.raw_frame     = in_ch.raw_frame;
  assign item.frame_length  = in_ch.frame_length;

  // Store: write requests land here; the read side always holds the byte at the
  // sequencer's pointer, with same-cycle writes forwarded, so a byte updated while
  // a frame runs goes out with its new value if it was not loaded yet.
  dmxtx_store #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .AW            (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Sequencer: break, mark-after-break, then start code and channel bytes as
  // 11-bit UART characters. Each tick request advances the timers by one.
  dmxtx_seq #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .AW            (AW),
    .PW            (PW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (in_fire),
    .item      (item),
    .cfg       (cfg),
    .rd_data   (st_rd_data),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_data   (st_wr_data),
    .rd_addr   (st_rd_addr),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_level   = out_res_r.tx_level;
  assign out_ch.busy_res   = out_res_r.busy_res;
  assign out_ch.frame_done = out_res_r.frame_done;

endmodule

[design/dmxtx_chk.sv]
// Port-level checker for the DMX512 frame transmitter, bound to the top level.
module dmxtx_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [dmxtx_pkg::KIND_W-1:0]    in_kind,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_tx_level,
  input logic                            out_busy_res,
  input logic                            out_frame_done
);
  import dmxtx_pkg::*;

  // a result left untaken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // input is held off only by a full, stalled output register
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // a start request reports break: line low, busy, not done
  a_start_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_START)
      |=> out_valid && out_busy_res && !out_frame_done && !out_tx_level)
    else $error("start request result wrong");

  // a frame cannot be both running and finished
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_busy_res && out_frame_done))
    else $error("busy and frame_done both set");

  // an idle line sits at mark
  a_idle_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_tx_level)
    else $error("line low while idle");

endmodule

bind dmx512_frame_transmitter_top dmxtx_chk u_dmxtx_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_kind        (in_ch.kind),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_tx_level   (out_ch.tx_level),
  .out_busy_res   (out_ch.busy_res),
  .out_frame_done (out_ch.frame_done)
);
